>>> design/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the sortable record stack
// Field widths, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package srs_pkg;

  // field widths
  localparam int TURN_W   = 16;
  localparam int DAMAGE_W = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 6;
  localparam int REC_W    = TURN_W + DAMAGE_W;

  // default stack depth
  localparam int DEPTH_DEF = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SORT = 2'd2
  } op_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_KEY_WAIT,
    S_PREV_CHK,
    S_PLACE
  } state_t;

endpackage

>>> design/srs_in_if.sv
// ----------------------------------------------------------------------------
// srs_in_if: command channel of the record stack
// Valid/ready channel carrying one operation and an optional record.
// ----------------------------------------------------------------------------
interface srs_in_if;
  import srs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [TURN_W-1:0]   rec_turn;
  logic [DAMAGE_W-1:0] rec_damage;

  modport source (output valid, output op, output rec_turn, output rec_damage,
                  input ready);
  modport sink   (input valid, input op, input rec_turn, input rec_damage,
                  output ready);
endinterface

>>> design/srs_out_if.sv
// ----------------------------------------------------------------------------
// srs_out_if: response channel of the record stack
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface srs_out_if;
  import srs_pkg::*;

  logic                valid;
  logic                ready;
  logic [TURN_W-1:0]   out_turn;
  logic [DAMAGE_W-1:0] out_damage;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill;

  modport source (output valid, output out_turn, output out_damage,
                  output status, output fill, input ready);
  modport sink   (input valid, input out_turn, input out_damage,
                  input status, input fill, output ready);
endinterface

>>> design/sortable_record_stack.sv
// ----------------------------------------------------------------------------
// sortable_record_stack: bounded stack of turn/damage records with a sort
// Push, pop and a stable descending sort by turn over a one-read, one-write store.
// ----------------------------------------------------------------------------
// Usage
//   cmd carries one operation per beat: push a record, pop the top record,
//   or sort the stored records by turn, largest at the bottom, ties kept in
//   push order. rsp returns exactly one beat per command with the popped
//   record (zero otherwise), a status code and the fill after the command.
// Sequencing
//   push, an empty pop, an unused code and a sort of fewer than two records:
//   result registered at the accepting edge.
//   pop: the record arrives from the store's registered read port in S_POP.
//   sort of n records: an insertion sort driven by one 16-bit comparator and
//   the store's single read and write port; S_KEY_WAIT takes each key and
//   S_PREV_CHK shifts smaller neighbors up before the key is written back.
//   cmd.ready is low while a command is in progress.
// Reset and stall
//   rst clears the fill count and the sequencer and holds cmd.ready low;
//   the store is not cleared.
//   A result waits in the output register while rsp.ready is low; the next
//   command is taken once that beat is leaving.
// ----------------------------------------------------------------------------
module sortable_record_stack #(
  parameter int DEPTH = srs_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srs_in_if.sink     cmd,
  srs_out_if.source  rsp
);
  import srs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  // record store
  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;

  // control registers
  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    idx_i, idx_i_next;
  logic [AW-1:0]    idx_j, idx_j_next;
  logic [REC_W-1:0] key, key_next;

  // result load
  logic                ld;
  logic [TURN_W-1:0]   ld_turn;
  logic [DAMAGE_W-1:0] ld_damage;
  status_t             ld_status;

  logic accept;
  logic prev_less;
  logic sort_last;

  assign cmd.ready = !rst && (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign prev_less = rd_data[REC_W-1:DAMAGE_W] < key[REC_W-1:DAMAGE_W];
  assign sort_last = (CW'(idx_i) + CW'(1)) == count;

  // store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // sort indexes and held key
  always_ff @(posedge clk) begin
    idx_i <= idx_i_next;
    idx_j <= idx_j_next;
    key   <= key_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    key_next   = key;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_j;
    wr_data    = key;
    ld         = 1'b0;
    ld_turn    = '0;
    ld_damage  = '0;
    ld_status  = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (cmd.op == OP_POP) begin
          rd_addr = AW'(count - CW'(1));
        end else begin
          rd_addr = AW'(1);
        end
        if (accept) begin
          unique case (cmd.op)
            OP_PUSH: begin
              ld = 1'b1;
              if (count == CW'(DEPTH)) begin
                ld_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count);
                wr_data    = {cmd.rec_turn, cmd.rec_damage};
                count_next = count + CW'(1);
              end
            end
            OP_POP: begin
              if (count == '0) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next = S_POP;
              end
            end
            OP_SORT: begin
              if (count < CW'(2)) begin
                ld = 1'b1;
              end else begin
                idx_i_next = AW'(1);
                state_next = S_KEY_WAIT;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end

      // popped record arrives from the store
      S_POP: begin
        ld         = 1'b1;
        ld_turn    = rd_data[REC_W-1:DAMAGE_W];
        ld_damage  = rd_data[DAMAGE_W-1:0];
        count_next = count - CW'(1);
        state_next = S_IDLE;
      end

      // take the key and fetch its left neighbor
      S_KEY_WAIT: begin
        key_next   = rd_data;
        idx_j_next = idx_i;
        rd_addr    = idx_i - AW'(1);
        state_next = S_PREV_CHK;
      end

      // shift the neighbor up while its turn is smaller than the key, else write the key
      S_PREV_CHK: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        if (prev_less) begin
          wr_data = rd_data;
          if (idx_j == AW'(1)) begin
            idx_j_next = '0;
            state_next = S_PLACE;
          end else begin
            idx_j_next = idx_j - AW'(1);
            rd_addr    = idx_j - AW'(2);
          end
        end else begin
          wr_data = key;
          if (sort_last) begin
            ld         = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_i_next = idx_i + AW'(1);
            rd_addr    = idx_i + AW'(1);
            state_next = S_KEY_WAIT;
          end
        end
      end

      // key lands at the bottom
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = key;
        if (sort_last) begin
          ld         = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_i_next = idx_i + AW'(1);
          rd_addr    = idx_i + AW'(1);
          state_next = S_KEY_WAIT;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ld) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rsp.out_turn   <= ld_turn;
      rsp.out_damage <= ld_damage;
      rsp.status     <= ld_status;
      rsp.fill       <= FILL_W'(count_next);
    end
  end

  // fill count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // a new result never overwrites a beat still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ld |-> (!rsp.valid || rsp.ready))
    else $error("result overwrote a pending beat");

  // insertion position never passes the key's own slot
  a_sort_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREV_CHK) |-> (idx_j <= idx_i && idx_j != '0))
    else $error("sort index out of order");

  // a pop of a non-empty stack answers after the store read in S_POP
  a_pop_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == OP_POP && count != '0) |-> ##2 rsp.valid)
    else $error("pop result missing");

endmodule
